// ===== rtl/core/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg
// Shared widths, reset values, register indexes and types for the pedometer.
// ----------------------------------------------------------------------------
package pps_pkg;

	localparam int MAG_WIDTH   = 16;
	localparam int CFG_WIDTH   = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int STEP_W      = 32;
	localparam int ACT_W       = 16;
	localparam int WIN_W       = 16;
	localparam int COOL_W      = 8;

	typedef logic [MAG_WIDTH-1:0] mag_t;
	typedef logic [STEP_W-1:0]    step_cnt_t;
	typedef logic [ACT_W-1:0]     act_cnt_t;
	typedef logic [WIN_W-1:0]     win_t;
	typedef logic [COOL_W-1:0]    cool_t;
	typedef logic [CFG_WIDTH-1:0] cfg_data_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// Register indexes of the configuration port
	localparam cfg_idx_t REG_PEAK_LEVEL       = 3'd0;
	localparam cfg_idx_t REG_COOLDOWN_SAMPLES = 3'd1;
	localparam cfg_idx_t REG_ACTIVE_THRESHOLD = 3'd2;
	localparam cfg_idx_t REG_WINDOW_LENGTH    = 3'd3;
	localparam cfg_idx_t REG_ACTIVE_NEEDED    = 3'd4;

	// Reset values: 1.15 g and 1.05 g in Q4.12, one minute at 50 Hz
	localparam mag_t     ONE_G            = mag_t'(4096);
	localparam mag_t     RST_STEP_THRESH  = mag_t'(4710);
	localparam cool_t    RST_COOLDOWN     = cool_t'(8);
	localparam mag_t     RST_ACTIVE_THRESH = mag_t'(4301);
	localparam win_t     RST_WINDOW_LEN   = win_t'(3000);
	localparam act_cnt_t RST_ACTIVE_NEEDED = act_cnt_t'(1500);

	// Step detector result for one sample
	typedef struct packed {
		step_cnt_t step_total;
		logic      step_seen;
	} step_res_t;

	// Activity window result for one sample
	typedef struct packed {
		act_cnt_t active_total;
		logic     window_done;
		logic     window_was_active;
	} act_res_t;

endpackage

// ===== rtl/core/pps_step_det.sv =====
// ----------------------------------------------------------------------------
// pps_step_det
// Peak detector with cooldown and a saturating step counter.
// ----------------------------------------------------------------------------
module pps_step_det (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  pps_pkg::mag_t    mag,
	input  pps_pkg::mag_t    peak_level,
	input  pps_pkg::cool_t   cooldown_samples,
	output pps_pkg::step_res_t res
);
	import pps_pkg::*;

	mag_t      last_q;
	mag_t      before_q;
	cool_t     cool_q;
	step_cnt_t count_q;

	logic      peak;
	logic      seen;
	cool_t     cool_next;
	step_cnt_t count_next;

	assign peak = (last_q > peak_level) && (last_q > before_q) && (last_q > mag);

	always_comb begin
		seen       = 1'b0;
		cool_next  = cool_q;
		count_next = count_q;
		if (cool_q != '0) begin
			cool_next = cool_q - cool_t'(1);
		end else if (peak) begin
			seen      = 1'b1;
			cool_next = cooldown_samples;
			if (count_q != '1) begin
				count_next = count_q + step_cnt_t'(1);
			end
		end
	end

	assign res.step_total = count_next;
	assign res.step_seen  = seen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= ONE_G;
			before_q <= ONE_G;
			cool_q   <= '0;
			count_q  <= '0;
		end else if (adv) begin
			before_q <= last_q;
			last_q   <= mag;
			cool_q   <= cool_next;
			count_q  <= count_next;
		end
	end

	a_seen_loads_cooldown: assert property (@(posedge clk) disable iff (!arst_n)
		adv && seen |=> cool_q == $past(cooldown_samples))
		else $error("cooldown not loaded after a counted step");

	a_no_step_in_cooldown: assert property (@(posedge clk) disable iff (!arst_n)
		adv && cool_q != '0 |=> count_q == $past(count_q))
		else $error("step counted while cooldown running");

endmodule

// ===== rtl/core/pps_activity.sv =====
// ----------------------------------------------------------------------------
// pps_activity
// Active-sample window counter and saturating active-minute counter.
// ----------------------------------------------------------------------------
module pps_activity (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  pps_pkg::mag_t     mag,
	input  pps_pkg::mag_t     active_threshold,
	input  pps_pkg::win_t     window_length,
	input  pps_pkg::act_cnt_t active_needed,
	output pps_pkg::act_res_t res
);
	import pps_pkg::*;

	act_cnt_t        samples_q;
	win_t            pos_q;
	act_cnt_t        minutes_q;

	act_cnt_t        samples_inc;
	logic [WIN_W:0]  pos_sum;
	logic            done;
	logic            was_active;
	act_cnt_t        samples_next;
	win_t            pos_next;
	act_cnt_t        minutes_next;

	always_comb begin
		samples_inc = samples_q;
		if (mag > active_threshold && samples_q != '1) begin
			samples_inc = samples_q + act_cnt_t'(1);
		end
		pos_sum      = {1'b0, pos_q} + {{WIN_W{1'b0}}, 1'b1};
		done         = pos_sum >= {1'b0, window_length};
		was_active   = done && (samples_inc > active_needed);
		minutes_next = minutes_q;
		if (was_active && minutes_q != '1) begin
			minutes_next = minutes_q + act_cnt_t'(1);
		end
		samples_next = done ? '0 : samples_inc;
		pos_next     = done ? '0 : pos_sum[WIN_W-1:0];
	end

	assign res.active_total      = minutes_next;
	assign res.window_done       = done;
	assign res.window_was_active = was_active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_q <= '0;
			pos_q     <= '0;
			minutes_q <= '0;
		end else if (adv) begin
			samples_q <= samples_next;
			pos_q     <= pos_next;
			minutes_q <= minutes_next;
		end
	end

	a_window_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && done |=> samples_q == '0 && pos_q == '0)
		else $error("window close did not clear the count");

endmodule

// ===== rtl/core/pedometer_peak_step_counter.sv =====
// ----------------------------------------------------------------------------
// pedometer_peak_step_counter
// Peak-detecting step counter with active-minute tracking.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / sample_mag) takes one Q4.12 magnitude
//   item per cycle while in_stall is low. Output channel (out_valid /
//   out_stall / result fields) returns exactly one result item per input
//   item, in order. An accepted item is captured in the input register and
//   processed into the result register once that register is free or being
//   emptied. Throughput: one item per cycle while the receiver does not
//   stall, set by the single compare-and-count pass between the two registers.
//   When the receiver stalls, the result register holds; one further item
//   waits in the input register, after which in_stall rises until the result
//   is taken. Reset clears both valid flags and loads the default register
//   values (1.15 g, cooldown 8, 1.05 g, window 3000, 1500 active samples);
//   history starts at one g. Write configuration only while idle; an index
//   beyond the register list is ignored.
// ----------------------------------------------------------------------------
module pedometer_peak_step_counter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  pps_pkg::mag_t       sample_mag,
	output logic                out_valid,
	input  logic                out_stall,
	output pps_pkg::step_cnt_t  step_total,
	output pps_pkg::act_cnt_t   active_total,
	output logic                step_seen,
	output logic                window_done,
	output logic                window_was_active,
	input  logic                cfg_we,
	input  pps_pkg::cfg_idx_t   cfg_index,
	input  pps_pkg::cfg_data_t  cfg_data
);
	import pps_pkg::*;

	// Configuration registers
	mag_t      peak_level_q;
	cool_t     cooldown_samples_q;
	mag_t      active_threshold_q;
	win_t      window_length_q;
	act_cnt_t  active_needed_q;

	// Input register
	logic      valid_s1;
	mag_t      mag_s1;

	// Result register
	logic      valid_s2;
	step_res_t step_s2;
	act_res_t  act_s2;

	step_res_t step_res;
	act_res_t  act_res;
	logic      adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_level_q       <= RST_STEP_THRESH;
			cooldown_samples_q <= RST_COOLDOWN;
			active_threshold_q <= RST_ACTIVE_THRESH;
			window_length_q    <= RST_WINDOW_LEN;
			active_needed_q    <= RST_ACTIVE_NEEDED;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PEAK_LEVEL:       peak_level_q       <= cfg_data;
				REG_COOLDOWN_SAMPLES: cooldown_samples_q <= cfg_data[COOL_W-1:0];
				REG_ACTIVE_THRESHOLD: active_threshold_q <= cfg_data;
				REG_WINDOW_LENGTH:    window_length_q    <= cfg_data;
				REG_ACTIVE_NEEDED:    active_needed_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the item in the input register when the result register is
	// free or being emptied this cycle.
	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	// Hold off the sender only while the input register is full and stuck.
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mag_s1 <= sample_mag;
		end
	end

	pps_step_det u_step_det (
		.clk              (clk),
		.arst_n           (arst_n),
		.adv              (adv),
		.mag              (mag_s1),
		.peak_level       (peak_level_q),
		.cooldown_samples (cooldown_samples_q),
		.res              (step_res)
	);

	pps_activity u_activity (
		.clk              (clk),
		.arst_n           (arst_n),
		.adv              (adv),
		.mag              (mag_s1),
		.active_threshold (active_threshold_q),
		.window_length    (window_length_q),
		.active_needed    (active_needed_q),
		.res              (act_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			step_s2 <= step_res;
			act_s2  <= act_res;
		end
	end

	assign out_valid         = valid_s2;
	assign step_total        = step_s2.step_total;
	assign step_seen         = step_s2.step_seen;
	assign active_total      = act_s2.active_total;
	assign window_done       = act_s2.window_done;
	assign window_was_active = act_s2.window_was_active;

	a_s1_holds_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(mag_s1))
		else $error("blocked item dropped from input register");

	a_adv_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("processed item missing from result register");

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_stall && !valid_s1 |=> !valid_s2)
		else $error("result repeated after being taken");

endmodule

// ===== verif/pedometer_peak_step_counter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedometer_peak_step_counter_tb
// Self-checking bench for the peak-detecting step counter and its
// active-minute window. A behavioural copy of the counter runs beside the
// block and predicts every result item. Both channels idle and stall at
// random. The run covers directed threshold, cooldown and window cases, a
// long receiver hold-off, a run of one-sample active windows, and randomised
// walking waveforms under a spread of register settings.
// ----------------------------------------------------------------------------
module pedometer_peak_step_counter_tb;
	import pps_pkg::*;

	localparam int SETTLE_CYCLES = 3;     // idle wait after the last result drains, with slack
	localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
	localparam int QUIET_LIMIT   = 4000;  // cycles without any handshake
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 150;
	localparam int ONE_WIN_ITEMS = 120;   // back-to-back one-sample windows

	// One predicted result item
	typedef struct {
		step_cnt_t steps;
		act_cnt_t  minutes;
		logic      seen;
		logic      done;
		logic      active;
	} reading_t;

	// Clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// Block inputs, all known from time zero
	logic      in_valid   = 1'b0;
	mag_t      sample_mag = ONE_G;
	logic      out_stall  = 1'b0;
	logic      cfg_we     = 1'b0;
	cfg_idx_t  cfg_index  = REG_PEAK_LEVEL;
	cfg_data_t cfg_data   = '0;

	// Block outputs
	logic      in_stall;
	logic      out_valid;
	step_cnt_t step_total;
	act_cnt_t  active_total;
	logic      step_seen;
	logic      window_done;
	logic      window_was_active;

	// Predictor: register copy, loaded with the reset values
	mag_t  thr_step     = RST_STEP_THRESH;
	cool_t cooldown_len = RST_COOLDOWN;
	mag_t  thr_active   = RST_ACTIVE_THRESH;
	win_t  window_len   = RST_WINDOW_LEN;
	act_cnt_t active_need = RST_ACTIVE_NEEDED;

	// Predictor: detector and window state
	mag_t      hist_last   = ONE_G;
	mag_t      hist_prev   = ONE_G;
	cool_t     cool_left   = '0;
	act_cnt_t  active_run  = '0;
	win_t      window_pos  = '0;
	step_cnt_t step_acc    = '0;
	act_cnt_t  minute_acc  = '0;

	reading_t pending_readings[$];

	// Run control and bookkeeping
	bit tx_idle_on   = 1'b1;
	bit rx_idle_on   = 1'b1;
	bit hold_request = 1'b0;
	int hold_left    = 0;
	int stall_left   = 0;
	int quiet_cycles = 0;
	int errors       = 0;
	int samples_sent = 0;
	int results_seen = 0;
	int steps_seen   = 0;
	int windows_seen = 0;
	int active_seen  = 0;
	int settings_run = 0;

	pedometer_peak_step_counter dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.sample_mag       (sample_mag),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.step_total       (step_total),
		.active_total     (active_total),
		.step_seen        (step_seen),
		.window_done      (window_done),
		.window_was_active(window_was_active),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Gap length for either side: mostly none or short, now and then long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		if (roll < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Advance the predicted counter by one accepted sample and queue the
	// result item it must produce.
	task automatic track_sample(input mag_t mag);
		reading_t   r;
		logic [16:0] pos_next;
		r.seen   = 1'b0;
		r.done   = 1'b0;
		r.active = 1'b0;
		// Peak test looks at the previous sample; a running cooldown skips it
		if (cool_left != '0) begin
			cool_left = cool_left - 1'b1;
		end else if (hist_last > thr_step && hist_last > hist_prev && hist_last > mag) begin
			r.seen = 1'b1;
			if (step_acc != '1) step_acc = step_acc + 1'b1;
			cool_left = cooldown_len;
		end
		hist_prev = hist_last;
		hist_last = mag;
		if (mag > thr_active && active_run != '1) active_run = active_run + 1'b1;
		// Window closes once the position reaches the length; length zero
		// closes on every sample, a shortened window on the next one
		pos_next = {1'b0, window_pos} + 17'd1;
		if (pos_next >= {1'b0, window_len}) begin
			r.done = 1'b1;
			if (active_run > active_need) begin
				r.active = 1'b1;
				if (minute_acc != '1) minute_acc = minute_acc + 1'b1;
			end
			active_run = '0;
			window_pos = '0;
		end else begin
			window_pos = pos_next[WIN_W-1:0];
		end
		r.steps   = step_acc;
		r.minutes = minute_acc;
		pending_readings.push_back(r);
	endtask

	// Offer one sample and hold it until the block takes it. Valid stays
	// high into the next call unless that call opens a gap.
	task automatic send_sample(input mag_t mag);
		int gap;
		gap = tx_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		sample_mag <= mag;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		track_sample(mag);
		samples_sent++;
	endtask

	// Drop valid, let every result drain, then give the pipeline a few cycles
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register; the caller lowers the write enable afterwards
	task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_PEAK_LEVEL:       thr_step     = val;
			REG_COOLDOWN_SAMPLES: cooldown_len = val[COOL_W-1:0];
			REG_ACTIVE_THRESHOLD: thr_active   = val;
			REG_WINDOW_LENGTH:    window_len   = val;
			REG_ACTIVE_NEEDED:    active_need  = val;
			default: ;
		endcase
	endtask

	// Load all five registers while the block is idle
	task automatic apply_settings(input cfg_data_t st, input cfg_data_t cd,
			input cfg_data_t at, input cfg_data_t wl, input cfg_data_t an);
		wait_idle();
		write_reg(REG_PEAK_LEVEL, st);
		write_reg(REG_COOLDOWN_SAMPLES, cd);
		write_reg(REG_ACTIVE_THRESHOLD, at);
		write_reg(REG_WINDOW_LENGTH, wl);
		write_reg(REG_ACTIVE_NEEDED, an);
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	// One stride: rise from a baseline to a peak, maybe dwell on it, fall back.
	// A dwell puts equal neighbours at the top, which must not count.
	task automatic send_stride();
		int base, peak, rise, fall, dwell, v;
		base  = $urandom_range(3000, 4600);
		peak  = $urandom_range(4200, 9000);
		rise  = $urandom_range(1, 4);
		fall  = $urandom_range(1, 4);
		dwell = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
		for (int i = 1; i <= rise; i++) begin
			v = base + (peak - base) * i / rise + $urandom_range(0, 60) - 30;
			send_sample(mag_t'(v));
		end
		repeat (dwell) send_sample(mag_t'(peak));
		for (int i = fall - 1; i >= 0; i--) begin
			v = base + (peak - base) * i / fall + $urandom_range(0, 60) - 30;
			send_sample(mag_t'(v));
		end
	endtask

	// Reset values written back, then a clean peak just over the step threshold,
	// a smaller peak inside the cooldown, and samples just over and at the activity threshold.
	task automatic test_default_settings();
		apply_settings(cfg_data_t'(RST_STEP_THRESH), cfg_data_t'(RST_COOLDOWN),
			cfg_data_t'(RST_ACTIVE_THRESH), cfg_data_t'(RST_WINDOW_LEN),
			cfg_data_t'(RST_ACTIVE_NEEDED));
		send_sample(ONE_G);
		send_sample(mag_t'(4711));
		send_sample(ONE_G);
		send_sample(mag_t'(4302));
		send_sample(mag_t'(4301));
		send_sample(ONE_G);
	endtask

	// Thresholds at both ends of their range, window length one and zero
	task automatic test_threshold_extremes();
		apply_settings('1, '0, '1, cfg_data_t'(1), '0);
		send_sample('0);
		send_sample('1);
		send_sample('0);
		send_sample('1);
		apply_settings('0, '0, '0, '0, '0);
		send_sample(mag_t'(1));
		send_sample('0);
		send_sample(mag_t'(2));
		send_sample(mag_t'(1));
		send_sample(mag_t'(3));
		send_sample('0);
	endtask

	// Cooldown register takes only its low byte; peaks close together
	// fall partly inside the cooldown.
	task automatic test_cooldown();
		apply_settings(cfg_data_t'(RST_STEP_THRESH), 16'hA503,
			cfg_data_t'(RST_ACTIVE_THRESH), cfg_data_t'(RST_WINDOW_LEN),
			cfg_data_t'(RST_ACTIVE_NEEDED));
		repeat (3) begin
			send_sample(mag_t'(5000));
			send_sample(ONE_G);
		end
	endtask

	// Shrink the window below the current position: next sample closes it
	task automatic test_window_shortened();
		repeat (4) send_sample(mag_t'(4500));
		apply_settings(cfg_data_t'(RST_STEP_THRESH), cfg_data_t'(RST_COOLDOWN),
			'0, cfg_data_t'(3), cfg_data_t'(2));
		send_sample(mag_t'(4500));
		send_sample(mag_t'(4500));
	endtask

	// Writes beyond the register list must leave every setting alone
	task automatic test_spare_indexes();
		wait_idle();
		for (int i = REG_ACTIVE_NEEDED + 1; i < 2 ** CFG_IDX_W; i++)
			write_reg(cfg_idx_t'(i), cfg_data_t'($urandom));
		cfg_we <= 1'b0;
		send_sample(mag_t'(7000));
		send_sample(ONE_G);
	endtask

	// Receiver holds off for a long stretch while samples keep coming,
	// so the block fills and raises its input stall.
	task automatic test_backpressure();
		wait_idle();
		tx_idle_on   = 1'b0;
		hold_request = 1'b1;
		repeat (8) send_stride();
		tx_idle_on = 1'b1;
	endtask

	// Every sample closes an active window of length one: active_total must
	// climb by one per item with no idling on either side.
	task automatic test_single_sample_windows();
		apply_settings(cfg_data_t'(RST_STEP_THRESH), cfg_data_t'(RST_COOLDOWN),
			'0, cfg_data_t'(1), '0);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		repeat (ONE_WIN_ITEMS) send_sample(mag_t'($urandom_range(1, 65535)));
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// Walking waveforms with noise, one register setting per phase
	task automatic test_random_walks();
		cfg_data_t st, cd, at, wl, an;
		int goal;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			st = ($urandom_range(0, 4) == 0) ? cfg_data_t'($urandom)
				: cfg_data_t'($urandom_range(4300, 6500));
			cd = ($urandom_range(0, 5) == 0) ? cfg_data_t'($urandom)
				: cfg_data_t'($urandom_range(0, 10));
			at = ($urandom_range(0, 4) == 0) ? cfg_data_t'($urandom)
				: cfg_data_t'($urandom_range(4000, 5500));
			case ($urandom_range(0, 9))
				0:       wl = '0;
				1:       wl = '1;
				2:       wl = cfg_data_t'($urandom_range(41, 400));
				default: wl = cfg_data_t'($urandom_range(1, 40));
			endcase
			an = ($urandom_range(0, 7) == 0) ? '1 : cfg_data_t'($urandom_range(0, wl));
			// first two phases pin every register to its top, then its bottom
			if (ph == 0) begin
				st = '1; cd = cfg_data_t'(cool_t'('1)); at = '1; wl = '1; an = '1;
			end else if (ph == 1) begin
				st = '0; cd = '0; at = '0; wl = '0; an = '0;
			end
			apply_settings(st, cd, at, wl, an);
			// some phases run with no idling on one side or the other
			tx_idle_on = (ph % 4) != 3;
			rx_idle_on = (ph % 3) != 2;
			goal = samples_sent + PHASE_ITEMS;
			while (samples_sent < goal) begin
				if ($urandom_range(0, 9) < 8) begin
					send_stride();
				end else begin
					case ($urandom_range(0, 5))
						0: send_sample('0);
						1: send_sample('1);
						2: send_sample(thr_step + 1'b1);
						3: send_sample(thr_active);
						default: send_sample(mag_t'($urandom));
					endcase
				end
			end
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// Receiver stall: a requested hold-off first, otherwise random gaps
	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left    = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			stall_left = rx_idle_on ? pick_gap() : 0;
			out_stall <= (stall_left != 0);
			if (stall_left > 0) stall_left--;
		end
	end

	task automatic compare_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Take each result item off the block and match it to the oldest prediction
	always @(posedge clk) begin : check_results
		reading_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_readings.size() == 0) begin
				$display("%0t ns: result item with no prediction waiting", $time);
				errors++;
			end else begin
				want = pending_readings.pop_front();
				compare_field("step_total", want.steps, step_total);
				compare_field("active_total", want.minutes, active_total);
				compare_field("step_seen", want.seen, step_seen);
				compare_field("window_done", want.done, window_done);
				compare_field("window_was_active", want.active, window_was_active);
				results_seen++;
				steps_seen   += want.seen;
				windows_seen += want.done;
				active_seen  += want.active;
			end
		end
	end

	// Watchdog: any handshake on either side resets the quiet count
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t ns: no handshake for %0d cycles", $time, QUIET_LIMIT);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_settings();
		test_threshold_extremes();
		test_cooldown();
		test_window_shortened();
		test_spare_indexes();
		test_backpressure();
		test_single_sample_windows();
		test_random_walks();

		wait_idle();
		if (pending_readings.size() != 0) begin
			$display("%0d predicted result items never arrived", pending_readings.size());
			errors++;
		end
		$display("Checked %0d result items from %0d samples over %0d register settings",
			results_seen, samples_sent, settings_run);
		$display("Seen %0d steps, %0d window closes, %0d active windows; %0d mismatches",
			steps_seen, windows_seen, active_seen, errors);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
